FILE: rtl/rfd_pkg.sv
// shared constants, types and register codes for the red flash frame detector
package rfd_pkg;

  // frame geometry
  localparam int SEGMENTS      = 1;
  localparam int FRAME_PIXELS  = 1200;
  localparam int HISTORY_DEPTH = 3;
  localparam int SEG_PIXELS    = FRAME_PIXELS / SEGMENTS;

  localparam int POS_W = (SEG_PIXELS > 1) ? $clog2(SEG_PIXELS) : 1;
  localparam int SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  // scoring and sums
  localparam int SUM_W   = 14;
  localparam int TOTAL_W = SUM_W + ((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0);
  localparam int CNT_W   = 5;
  localparam logic [SUM_W-1:0] PIXEL_SCORE = SUM_W'(10);
  localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

  // mean by reciprocal multiply, exact for every total below 2**TOTAL_W
  localparam int MEAN_SHIFT = TOTAL_W +
                              2 * ((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0);
  localparam int RECIP_W    = MEAN_SHIFT + 1;
  localparam int PROD_W     = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'((2 ** MEAN_SHIFT + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

  // compare width for 2*sum against 5*mean
  localparam int CMP_W = SUM_W + 3;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_RED_THRESHOLD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_THRESHOLD = 1'd1;
  localparam logic [7:0] RED_THRESHOLD_RST   = 8'd178;
  localparam logic [7:0] GREEN_THRESHOLD_RST = 8'd77;

  // rgb565 field masks
  localparam logic [7:0] RED_MASK = 8'hF8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
  } thresh_t;

  // one segment close and/or frame end, handed from front to back
  typedef struct packed {
    logic             close;
    logic             emit;
    logic [SEG_W-1:0] seg;
    logic [SUM_W-1:0] sum;
  } close_ev_t;

endpackage

FILE: rtl/rfd_front.sv
// front end: pixel classification, segment accumulation and close events
module rfd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  rfd_pkg::thresh_t   thresh,
  input  logic               pix_valid,
  input  logic [15:0]        pix_word,
  input  logic               pix_last,
  output logic               ev_push,
  output rfd_pkg::close_ev_t ev_data
);

  logic [rfd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [rfd_pkg::SEG_W-1:0] seg_r, seg_nxt;
  logic [rfd_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                      overrun_r, overrun_nxt;

  logic [7:0]                red8;
  logic [7:0]                green8;
  logic                      hit;
  logic [rfd_pkg::SUM_W:0]   sum_add;
  logic [rfd_pkg::SUM_W-1:0] sum_sat;
  logic                      last_of_seg;
  logic                      close;

  assign red8   = pix_word[15:8] & rfd_pkg::RED_MASK;
  assign green8 = {pix_word[10:5], 2'b00};
  assign hit    = (red8 > thresh.red) && (green8 < thresh.green);

  assign sum_add = {1'b0, sum_r} + (hit ? {1'b0, rfd_pkg::PIXEL_SCORE} : '0);
  assign sum_sat = sum_add[rfd_pkg::SUM_W] ? rfd_pkg::SUM_MAX : sum_add[rfd_pkg::SUM_W-1:0];

  assign last_of_seg = (pos_r == rfd_pkg::POS_W'(rfd_pkg::SEG_PIXELS - 1));
  assign close       = !overrun_r && (last_of_seg || pix_last);

  assign ev_push       = pix_valid && (close || pix_last);
  assign ev_data.close = close;
  assign ev_data.emit  = pix_last;
  assign ev_data.seg   = seg_r;
  assign ev_data.sum   = sum_sat;

  always_comb begin
    pos_nxt     = pos_r;
    seg_nxt     = seg_r;
    sum_nxt     = sum_r;
    overrun_nxt = overrun_r;
    if (pix_valid) begin
      if (pix_last) begin
        pos_nxt     = '0;
        seg_nxt     = '0;
        sum_nxt     = '0;
        overrun_nxt = 1'b0;
      end else if (!overrun_r) begin
        if (last_of_seg) begin
          pos_nxt = '0;
          sum_nxt = '0;
          if (seg_r == rfd_pkg::SEG_W'(rfd_pkg::SEGMENTS - 1)) begin
            overrun_nxt = 1'b1;
          end else begin
            seg_nxt = seg_r + 1'b1;
          end
        end else begin
          pos_nxt = pos_r + 1'b1;
          sum_nxt = sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      seg_r     <= '0;
      sum_r     <= '0;
      overrun_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      seg_r     <= seg_nxt;
      sum_r     <= sum_nxt;
      overrun_r <= overrun_nxt;
    end
  end

endmodule

FILE: rtl/rfd_queue.sv
// small fifo of close events between front and back
module rfd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rfd_pkg::close_ev_t push_data,
  output logic               full,
  input  logic               pop,
  output rfd_pkg::close_ev_t pop_data,
  output logic               empty
);

  rfd_pkg::close_ev_t          mem_r [rfd_pkg::QUEUE_DEPTH];
  logic [rfd_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [rfd_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [rfd_pkg::QPTR_W:0]    count_r;

  assign full     = (count_r == (rfd_pkg::QPTR_W+1)'(rfd_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/rfd_back.sv
// back end: history mean, detect decision, per-frame count and result register
module rfd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ev_empty,
  input  rfd_pkg::close_ev_t        ev_data,
  output logic                      ev_pop,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [rfd_pkg::CNT_W-1:0] res_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [rfd_pkg::SUM_W-1:0]   hist_r  [rfd_pkg::SEGMENTS][rfd_pkg::HISTORY_DEPTH];
  logic [rfd_pkg::TOTAL_W-1:0] total_r [rfd_pkg::SEGMENTS];
  logic [rfd_pkg::SEGMENTS-1:0] prev_r;

  rfd_pkg::close_ev_t          ev_r;
  logic [rfd_pkg::PROD_W-1:0]  prod_r;
  logic [rfd_pkg::CNT_W-1:0]   count_r;
  logic                        out_valid_r;
  logic [rfd_pkg::CNT_W-1:0]   out_data_r;

  logic [rfd_pkg::SUM_W-1:0]   mean;
  logic [rfd_pkg::CMP_W-1:0]   lhs;
  logic [rfd_pkg::CMP_W-1:0]   rhs;
  logic                        above;
  logic                        out_busy;
  logic                        commit;
  logic                        new_detect;
  logic [rfd_pkg::CNT_W-1:0]   count_after;
  logic [rfd_pkg::SUM_W-1:0]   stored;
  logic [rfd_pkg::TOTAL_W-1:0] total_new;

  assign mean  = prod_r[rfd_pkg::MEAN_SHIFT +: rfd_pkg::SUM_W];
  assign lhs   = rfd_pkg::CMP_W'(ev_r.sum) << 1;
  assign rhs   = (rfd_pkg::CMP_W'(mean) << 2) + rfd_pkg::CMP_W'(mean);
  assign above = lhs > rhs;

  assign out_busy = out_valid_r && !res_ready;
  assign commit   = (state_r == S_EVAL) && !(ev_r.emit && out_busy);

  assign new_detect  = ev_r.close && above && !prev_r[ev_r.seg];
  assign count_after = (new_detect && (count_r != rfd_pkg::CNT_MAX)) ?
                       count_r + 1'b1 : count_r;
  assign stored      = (above && prev_r[ev_r.seg]) ? '0 : ev_r.sum;
  assign total_new   = total_r[ev_r.seg]
                     - rfd_pkg::TOTAL_W'(hist_r[ev_r.seg][rfd_pkg::HISTORY_DEPTH-1])
                     + rfd_pkg::TOTAL_W'(stored);

  assign ev_pop = (state_r == S_IDLE) && !ev_empty;

  assign res_valid = out_valid_r;
  assign res_count = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!ev_empty) state_nxt = S_EVAL;
      S_EVAL:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // mean product, registered before the compare
  always_ff @(posedge clk) begin
    if (ev_pop) begin
      ev_r   <= ev_data;
      prod_r <= rfd_pkg::PROD_W'(total_r[ev_data.seg]) * rfd_pkg::PROD_W'(rfd_pkg::MEAN_RECIP);
    end
    if (commit && ev_r.emit) begin
      out_data_r <= count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      for (int s = 0; s < rfd_pkg::SEGMENTS; s++) begin
        total_r[s] <= '0;
        for (int k = 0; k < rfd_pkg::HISTORY_DEPTH; k++) begin
          hist_r[s][k] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (res_ready) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        if (ev_r.close) begin
          for (int k = rfd_pkg::HISTORY_DEPTH - 1; k > 0; k--) begin
            hist_r[ev_r.seg][k] <= hist_r[ev_r.seg][k-1];
          end
          hist_r[ev_r.seg][0] <= stored;
          total_r[ev_r.seg]   <= total_new;
          prev_r[ev_r.seg]    <= above;
        end
        if (ev_r.emit) begin
          out_valid_r <= 1'b1;
          count_r     <= '0;
        end else begin
          count_r <= count_after;
        end
      end
    end
  end

endmodule

FILE: rtl/red_flash_frame_detector_unit.sv
// top level of the red flash frame detector
//
// counts, per camera frame, the segments in which a red flash newly appears.
// input channel in_*: one rgb565 pixel per word in raster order, in_tlast on
// the last pixel of the frame. a pixel is taken every cycle while in_tready is
// high. output channel out_*: one word per frame, the number of segments
// that detected, sent after the word carrying in_tlast.
// segment closes and frame ends go through a four-entry event queue to the
// back end, which takes one event at a time (mean multiply, then compare
// and history update). pixels that close nothing never touch the queue, so
// the sustained rate is one pixel per cycle; in_tready falls only when four
// events wait. the frame-end event reaches out_tvalid through the queue, the
// mean multiply, the compare and the output register.
// the result sits in an output register; a stalled receiver holds only the
// next frame-end event in the back end, while pixels keep flowing until the
// queue fills.
// reset (rst_n low, synchronous) clears thresholds to their defaults, the
// pixel position, sums, history, previous-detect flags and the output.
// configuration: cfg_we writes cfg_wdata into the register cfg_addr selects.
module red_flash_frame_detector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel input
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,  // [15:0] pixel_word
  input  logic                           in_tlast,  // frame_end
  // result output
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata, // [4:0] detected_segments, rest zero
  // configuration writes
  input  logic                           cfg_we,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rfd_pkg::thresh_t   thresh_r;

  logic               in_fire;
  logic               ev_push;
  rfd_pkg::close_ev_t ev_in;
  logic               q_full;
  logic               q_empty;
  logic               ev_pop;
  rfd_pkg::close_ev_t ev_out;
  logic [rfd_pkg::CNT_W-1:0] res_count;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.red   <= rfd_pkg::RED_THRESHOLD_RST;
      thresh_r.green <= rfd_pkg::GREEN_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rfd_pkg::REG_RED_THRESHOLD:   thresh_r.red   <= cfg_wdata;
        rfd_pkg::REG_GREEN_THRESHOLD: thresh_r.green <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // accept while the event queue has room
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  rfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .thresh    (thresh_r),
    .pix_valid (in_fire),
    .pix_word  (in_tdata),
    .pix_last  (in_tlast),
    .ev_push   (ev_push),
    .ev_data   (ev_in)
  );

  rfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data (ev_in),
    .full      (q_full),
    .pop       (ev_pop),
    .pop_data  (ev_out),
    .empty     (q_empty)
  );

  rfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_empty  (q_empty),
    .ev_data   (ev_out),
    .ev_pop    (ev_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_count (res_count)
  );

  // pad the count to a whole byte
  assign out_tdata = {{(8 - rfd_pkg::CNT_W){1'b0}}, res_count};

endmodule

FILE: rtl/rfd_checker.sv
// port-level checks for the red flash frame detector, bound to the top level
module rfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a held result keeps its word until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // each segment detects at most once per frame
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[rfd_pkg::CNT_W-1:0] <= rfd_pkg::CNT_W'(rfd_pkg::SEGMENTS))
    else $error("detected segment count above segment total");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:rfd_pkg::CNT_W] == '0)
    else $error("nonzero padding in result word");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind red_flash_frame_detector_unit rfd_checker u_rfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: dv/testbench.sv
// self-checking testbench for the red flash frame detector unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // frame geometry and scoring as the block sees it
  localparam int unsigned SEG_PIX     = rfd_pkg::SEG_PIXELS;
  localparam int unsigned SCORED_PIX  = rfd_pkg::SEG_PIXELS * rfd_pkg::SEGMENTS;
  localparam int unsigned HIT_SCORE   = 10;
  localparam int unsigned SUM_CAP     = 16383;
  localparam int unsigned COUNT_CAP   = 31;

  // run shaping
  localparam int unsigned NUM_SETTINGS  = 8;
  localparam int unsigned HOLD_SETTING  = 2;    // setting during which the sink holds off
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 8;    // back end latency plus margin
  localparam int unsigned END_CYCLES    = 20;
  localparam int unsigned MIN_FRAMES    = 7;    // frames per setting, at least
  localparam int unsigned MIN_WORDS     = 60;   // pixel words per setting, at least
  localparam int unsigned NUM_ROWS      = 17;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [15:0]                    in_tdata;   // [15:0] pixel_word
  logic                           in_tlast;   // frame_end
  logic                           out_tvalid;
  logic                           out_tready;
  logic [7:0]                     out_tdata;  // [4:0] detected_segments, [7:5] zero
  logic                           cfg_we;
  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  red_flash_frame_detector_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // one directed pixel word; want is the typed frame count, or -1 where the
  // predictor supplies it
  typedef struct packed {
    logic [15:0]       pixel;
    logic              last;
    logic signed [7:0] want;
  } pixel_row_t;

  pixel_row_t dir_rows [NUM_ROWS];

  // mirror of the block's thresholds and detection state
  logic [7:0]  red_level;
  logic [7:0]  green_level;
  int unsigned pix_pos;
  int unsigned run_sum;
  int unsigned sum_hist [rfd_pkg::SEGMENTS][rfd_pkg::HISTORY_DEPTH];
  bit          flash_seen [rfd_pkg::SEGMENTS];
  int unsigned flash_count;
  bit          frame_full;

  // frame counts still owed by the block, oldest first
  logic [4:0] flash_counts_due [$];

  // run control shared between the driver and the sink
  bit          quiet;       // no idling on either side
  bit          hold_req;    // sink holds off for a long stretch
  int unsigned gap_odds;    // sender idles on one word in gap_odds, 0 = never

  // bookkeeping for the summary
  int unsigned words_sent;
  int unsigned frames_sent;
  int unsigned counts_seen;
  int unsigned flash_frames;
  int unsigned stall_cycles;
  int unsigned fail_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // predicts the detected segment count; returns 1 when the word ends a frame
  function automatic bit predict_flash_count(input logic [15:0] pw, input logic last,
                                             output logic [4:0] count_out);
    logic [7:0]  red8;
    logic [7:0]  green8;
    int unsigned seg;
    int unsigned total;
    int unsigned mean;
    int unsigned stored;
    int          k;
    count_out = '0;
    if (!frame_full) begin
      // rgb565 widened to 8 bits by zero fill
      red8   = {pw[15:11], 3'b000};
      green8 = {pw[10:5], 2'b00};
      if (red8 > red_level && green8 < green_level)
        run_sum = (run_sum + HIT_SCORE > SUM_CAP) ? SUM_CAP : run_sum + HIT_SCORE;
      // segment closes on its last pixel or on an early frame end
      if (pix_pos % SEG_PIX == SEG_PIX - 1 || last) begin
        seg = pix_pos / SEG_PIX;
        if (seg >= rfd_pkg::SEGMENTS)
          seg = rfd_pkg::SEGMENTS - 1;
        total = 0;
        for (k = 0; k < rfd_pkg::HISTORY_DEPTH; k++)
          total += sum_hist[seg][k];
        mean   = total / rfd_pkg::HISTORY_DEPTH;
        stored = run_sum;
        // sum > 2.5 * mean, kept in integers
        if (2 * run_sum > 5 * mean) begin
          if (flash_seen[seg])
            stored = 0;          // repeat flash: suppressed, history gets zero
          else if (flash_count < COUNT_CAP)
            flash_count++;
          flash_seen[seg] = 1'b1;
        end else begin
          flash_seen[seg] = 1'b0;
        end
        for (k = rfd_pkg::HISTORY_DEPTH - 1; k > 0; k--)
          sum_hist[seg][k] = sum_hist[seg][k - 1];
        sum_hist[seg][0] = stored;
        run_sum = 0;
      end
      // past the last scored pixel everything waits for the frame end
      if (pix_pos + 1 >= SCORED_PIX)
        frame_full = 1'b1;
      else
        pix_pos++;
    end
    if (last) begin
      count_out   = 5'(flash_count);
      pix_pos     = 0;
      run_sum     = 0;
      flash_count = 0;
      frame_full  = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // offers one pixel word, with a random idle burst ahead of it
  task automatic send_pixel(input logic [15:0] pw, input logic last, input int typed);
    int unsigned gap;
    logic [4:0]  due;
    gap = 0;
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
      gap = $urandom_range(1, 18);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pw;
    in_tlast  <= last;
    // word moves at the first rising edge with in_tready high
    do begin
      @(posedge clk);
      if (!in_tready)
        stall_cycles++;
    end while (!in_tready);
    words_sent++;
    if (predict_flash_count(pw, last, due)) begin
      frames_sent++;
      flash_counts_due.push_back(typed >= 0 ? 5'(typed) : due);
    end
  endtask

  // one frame of len pixels; density in quarters sets the share of red pixels
  task automatic send_frame(input int unsigned len, input int unsigned density);
    logic [15:0] pw;
    int unsigned n;
    for (n = 0; n < len; n++) begin
      if ($urandom_range(1, 4) <= density)
        pw = {5'($urandom_range(23, 31)), 6'($urandom_range(0, 15)), 5'($urandom)};
      else
        pw = 16'($urandom);
      send_pixel(pw, n == len - 1, -1);
    end
  endtask

  // drops in_tvalid, then waits until every owed count is back and the
  // back end has settled
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (flash_counts_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rfd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      rfd_pkg::REG_RED_THRESHOLD:   red_level   = val;
      rfd_pkg::REG_GREEN_THRESHOLD: green_level = val;
      default: ;
    endcase
  endtask

  // result checker: every word taken on the output is matched to the oldest count
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      counts_seen++;
      if (flash_counts_due.size() == 0) begin
        $error("out word with no frame pending: detected_segments %0d", out_tdata[4:0]);
        fail_count++;
      end else begin
        if (out_tdata[4:0] !== flash_counts_due[0]) begin
          $error("detected_segments: expected %0d, got %0d",
                 flash_counts_due[0], out_tdata[4:0]);
          fail_count++;
        end
        if (out_tdata[7:5] !== 3'b000) begin
          $error("out_tdata padding: expected 0, got %0d", out_tdata[7:5]);
          fail_count++;
        end
        if (flash_counts_due[0] != 0)
          flash_frames++;
        void'(flash_counts_due.pop_front());
      end
    end
  end

  // sink: random stalls, one long hold-off on request, none when quiet
  initial begin : sink
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold while the driver keeps going, so the event queue fills
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned setting;
    int unsigned first_word;
    int unsigned frame_cnt;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  red_set;
    logic [7:0]  green_set;
    int          s;
    int          k;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= rfd_pkg::REG_RED_THRESHOLD;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;

    quiet        = 1'b0;
    hold_req     = 1'b0;
    gap_odds     = 5;
    words_sent   = 0;
    frames_sent  = 0;
    counts_seen  = 0;
    flash_frames = 0;
    stall_cycles = 0;
    fail_count   = 0;

    // predictor starts from the reset state
    red_level   = rfd_pkg::RED_THRESHOLD_RST;
    green_level = rfd_pkg::GREEN_THRESHOLD_RST;
    pix_pos     = 0;
    run_sum     = 0;
    flash_count = 0;
    frame_full  = 1'b0;
    for (s = 0; s < rfd_pkg::SEGMENTS; s++) begin
      flash_seen[s] = 1'b0;
      for (k = 0; k < rfd_pkg::HISTORY_DEPTH; k++)
        sum_hist[s][k] = 0;
    end

    // directed words under the reset thresholds (red > 178, green < 77)
    dir_rows = '{
      // one red pixel against an empty history: new flash
      '{16'hF800, 1'b1, 8'sd1},
      // same again: still above the mean, but a repeat, so suppressed
      '{16'hF800, 1'b1, 8'sd0},
      // black, all-ones (green too high) and pure green: no score, no flash
      '{16'h0000, 1'b1, 8'sd0},
      '{16'hFFFF, 1'b1, 8'sd0},
      '{16'h07E0, 1'b1, 8'sd0},
      // two red pixels, blue at full scale on the second
      '{16'hF800, 1'b0, -8'sd1},
      '{16'hF81F, 1'b1, 8'sd1},
      // red 128 stays below the threshold
      '{16'h8000, 1'b1, 8'sd0},
      // threshold edges: red 176 misses, red 184 hits, green 76 hits, green 80 misses
      '{16'hB000, 1'b0, -8'sd1},
      '{16'hB800, 1'b0, -8'sd1},
      '{16'hBA60, 1'b0, -8'sd1},
      '{16'hBA80, 1'b0, -8'sd1},
      '{16'h001F, 1'b1, -8'sd1},
      // three red pixels against a raised mean
      '{16'hF800, 1'b0, -8'sd1},
      '{16'hF800, 1'b0, -8'sd1},
      '{16'hF800, 1'b1, -8'sd1},
      // upper half of the word set, lower clear
      '{16'hFF00, 1'b1, -8'sd1}
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < NUM_ROWS; k++)
      send_pixel(dir_rows[k].pixel, dir_rows[k].last, int'(dir_rows[k].want));
    wait_idle();

    // random frames under a series of threshold settings
    for (setting = 0; setting < NUM_SETTINGS; setting++) begin
      case (setting)
        1:       begin red_set = 8'd255; green_set = 8'd255; end  // no red passes
        2:       begin red_set = 8'd0;   green_set = 8'd0;   end  // no green passes
        3:       begin red_set = 8'd0;   green_set = 8'd255; end  // nearly all score
        4:       begin red_set = 8'd247; green_set = 8'd253; end  // top codes only
        7:       begin
          red_set   = rfd_pkg::RED_THRESHOLD_RST;
          green_set = rfd_pkg::GREEN_THRESHOLD_RST;
        end
        default: begin red_set = 8'($urandom); green_set = 8'($urandom); end
      endcase
      write_reg(rfd_pkg::REG_RED_THRESHOLD, red_set);
      write_reg(rfd_pkg::REG_GREEN_THRESHOLD, green_set);
      @(negedge clk);
      cfg_we <= 1'b0;

      quiet    = (setting == NUM_SETTINGS - 1);   // last stretch runs flat out
      gap_odds = (setting % 3 == 1) ? 0 : 5;
      if (setting == HOLD_SETTING)
        hold_req = 1'b1;

      first_word = words_sent;
      frame_cnt  = 0;
      while (frame_cnt < MIN_FRAMES || words_sent - first_word < MIN_WORDS) begin
        pick = $urandom_range(0, 99);
        if (setting == 0 && frame_cnt == 0)
          len = SCORED_PIX + $urandom_range(1, 30);          // full segment, late frame end
        else if (pick < 35)
          len = $urandom_range(1, 4);
        else
          len = $urandom_range(5, 24);
        send_frame(len, $urandom_range(0, 4));
        frame_cnt++;
      end
      // sender stops until every count of this setting is back
      wait_idle();
    end

    repeat (END_CYCLES) @(posedge clk);
    $display("%0d pixel words in %0d frames over %0d threshold settings, %0d counts checked",
             words_sent, frames_sent, NUM_SETTINGS + 1, counts_seen);
    $display("%0d frames reported a flash, input held off on %0d cycles",
             flash_frames, stall_cycles);
    if (fail_count == 0 && flash_counts_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rfd_pkg.sv
rtl/rfd_front.sv
rtl/rfd_queue.sv
rtl/rfd_back.sv
rtl/red_flash_frame_detector_unit.sv
rtl/rfd_checker.sv
dv/testbench.sv
